>>> design/k_stacks_shared_buffer_assert.svh
// Assertion macros used by the datapath design file (kssb_dp).
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef K_STACKS_SHARED_BUFFER_ASSERT_SVH
`define K_STACKS_SHARED_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSSB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSSB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kssb_pkg.sv
`default_nettype none
package kssb_pkg;

  localparam int IdW   = 2;
  localparam int IdN   = 1 << IdW;
  localparam int DataW = 32;

  localparam logic [DataW-1:0] EMPTY_WORD = 32'h7FFF_FFFF;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> design/kssb_ram.sv
`default_nettype none
module kssb_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> design/kssb_ctrl.sv
`default_nettype none
module kssb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kssb_pkg::sts_t sts_i,
  output kssb_pkg::ctl_t     ctl_o
);
  import kssb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ctl_o.accept = 1'b0;
    ctl_o.exec   = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        // The commit waits until the result register can take the result.
        if (!sts_i.out_busy) begin
          ctl_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/kssb_dp.sv
`default_nettype none
module kssb_dp #(
  parameter int NUM_STACKS = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire kssb_pkg::ctl_t                  ctl_i,
  output kssb_pkg::sts_t                       sts_o,
  input  wire logic                            cmd_i,
  input  wire logic [kssb_pkg::IdW-1:0]        stack_id_i,
  input  wire logic signed [kssb_pkg::DataW-1:0] value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [kssb_pkg::DataW-1:0]    pop_value_o,
  output logic [1:0]                           status_o,
  output logic                                 store_full_o,
  output logic                                 stack_empty_o
);
  import kssb_pkg::*;

  `include "k_stacks_shared_buffer_assert.svh"

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PtrW = $clog2(NUM_SLOTS + 1);
  localparam logic [PtrW-1:0] Nil = PtrW'(NUM_SLOTS);

  // Operation held between accept and commit.
  cmd_e               op_q;
  logic [IdW-1:0]     id_q;
  logic [DataW-1:0]   val_q;
  logic [PtrW-1:0]    slot_q;
  logic               hit_q;
  logic               idok_q;

  // List heads and fill count. Slots at or above hwm_q were never taken, so their
  // link entry was never written; link_nx uses slot plus one in its place.
  logic [PtrW-1:0]    free_head_q, free_head_d;
  logic [PtrW-1:0]    hwm_q, hwm_d;
  logic [PtrW-1:0]    head_q [IdN];
  logic [PtrW-1:0]    head_d [IdN];

  logic               out_valid_q;
  logic [DataW-1:0]   pop_q, pop_d;
  status_e            status_q, status_d;
  logic               full_q, full_d;
  logic               empty_q, empty_d;

  logic               id_ok;
  logic [PtrW-1:0]    slot_rd;
  logic [PtrW-1:0]    link_rdata;
  logic [DataW-1:0]   data_rdata;
  logic [PtrW-1:0]    link_nx;
  logic               link_we, data_we;
  logic [PtrW-1:0]    link_wdata;

  assign id_ok   = int'(stack_id_i) < NUM_STACKS;
  assign slot_rd = (cmd_e'(cmd_i) == CMD_PUSH) ? free_head_q
                 : (id_ok ? head_q[stack_id_i] : Nil);

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      op_q   <= cmd_e'(cmd_i);
      id_q   <= stack_id_i;
      val_q  <= value_i;
      slot_q <= slot_rd;
      hit_q  <= id_ok && (slot_rd != Nil);
      idok_q <= id_ok;
    end
  end

  kssb_ram #(.W(PtrW), .DEPTH(NUM_SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (slot_q[IdxW-1:0]),
    .wdata_i (link_wdata),
    .re_i    (ctl_i.accept),
    .raddr_i (slot_rd[IdxW-1:0]),
    .rdata_o (link_rdata)
  );

  kssb_ram #(.W(DataW), .DEPTH(NUM_SLOTS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q[IdxW-1:0]),
    .wdata_i (val_q),
    .re_i    (ctl_i.accept),
    .raddr_i (slot_rd[IdxW-1:0]),
    .rdata_o (data_rdata)
  );

  assign link_nx = (slot_q < hwm_q) ? link_rdata : PtrW'(slot_q + 1'b1);

  always_comb begin
    free_head_d = free_head_q;
    hwm_d       = hwm_q;
    head_d      = head_q;
    link_we     = 1'b0;
    data_we     = 1'b0;
    link_wdata  = free_head_q;
    pop_d       = '0;
    status_d    = ST_DONE;
    if (ctl_i.exec) begin
      if (op_q == CMD_PUSH) begin
        if (hit_q) begin
          free_head_d  = link_nx;
          link_we      = 1'b1;
          link_wdata   = head_q[id_q];
          head_d[id_q] = slot_q;
          data_we      = 1'b1;
          if (slot_q == hwm_q) begin
            hwm_d = PtrW'(hwm_q + 1'b1);
          end
        end else begin
          status_d = ST_OVERFLOW;
        end
      end else begin
        if (hit_q) begin
          head_d[id_q] = link_nx;
          link_we      = 1'b1;
          link_wdata   = free_head_q;
          free_head_d  = slot_q;
          pop_d        = data_rdata;
        end else begin
          status_d = ST_UNDERFLOW;
          pop_d    = EMPTY_WORD;
        end
      end
    end
    full_d  = (free_head_d == Nil);
    empty_d = idok_q ? (head_d[id_q] == Nil) : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < IdN; i++) begin
        head_q[i] <= Nil;
      end
    end else begin
      free_head_q <= free_head_d;
      hwm_q       <= hwm_d;
      head_q      <= head_d;
      out_valid_q <= ctl_i.exec || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      full_q   <= full_d;
      empty_q  <= empty_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign pop_value_o    = pop_q;
  assign status_o       = status_q;
  assign store_full_o   = full_q;
  assign stack_empty_o  = empty_q;

  `KSSB_ASSERT_NOW(a_full_means_all_taken, free_head_q == Nil, hwm_q == Nil,
                   "free list is empty while some slots were never taken")
  `KSSB_ASSERT_NOW(a_fill_in_range, 1'b1, hwm_q <= Nil,
                   "fill count ran past the slot count")
  `KSSB_ASSERT_NEXT(a_commit_shows_result, ctl_i.exec, out_valid_q,
                    "commit did not present a result")
  `KSSB_ASSERT_NOW(a_commit_not_over_result, ctl_i.exec, !(out_valid_q && out_stall_i),
                   "commit overwrote a result that was not yet transferred")

endmodule
`default_nettype wire

>>> design/k_stacks_shared_buffer.sv
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o      | cmd_i, stack_id_i, value_i
// out      | output    | out_valid_o / out_stall_i    | pop_value_o, status_o, store_full_o,
//          |           |                              | stack_empty_o
//
// Each operation is accepted, which reads the link and data memories, and then committed,
// which updates the lists and loads the result register once that register is free.
// A new operation is accepted only after the previous one has committed.
// A result waiting on out_stall_i does not block the next accept; the commit of that
// next operation waits until the result register is free.
// After reset all stacks are empty and all slots are free at once; a fill count stands
// in for the initial free chain, so no clearing pass is needed.
`default_nettype none
module k_stacks_shared_buffer #(
  parameter int NUM_STACKS = 4,
  parameter int NUM_SLOTS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic [kssb_pkg::IdW-1:0]          stack_id_i,
  input  wire logic signed [kssb_pkg::DataW-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [kssb_pkg::DataW-1:0]      pop_value_o,
  output logic [1:0]                             status_o,
  output logic                                   store_full_o,
  output logic                                   stack_empty_o
);
  import kssb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  kssb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  kssb_dp #(
    .NUM_STACKS (NUM_STACKS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (cmd_i),
    .stack_id_i    (stack_id_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .store_full_o  (store_full_o),
    .stack_empty_o (stack_empty_o)
  );

endmodule
`default_nettype wire
